/* rtl/efsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package efsd_pkg;

  // default server pool size and register reset value
  localparam int          MAX_SERVERS_DEF = 16;
  localparam logic [4:0]  NUM_SERVERS_RST = 5'd16;

  // one job request
  typedef struct packed {
    logic [15:0] service_time;
    logic        first_of_case;
    logic        last_of_case;
  } in_req_t;

  // one dispatch result
  typedef struct packed {
    logic [3:0]  assigned_server;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [3:0]  next_free_server;
    logic        answer_valid;
  } out_res_t;

  // dispatch sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

/* rtl/efsd_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Finish-time memory: one write and one registered read port.
// Per-entry valid bits make an unwritten or cleared entry read as zero.
module efsd_store #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr_all,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output logic      [31:0]   rd_data
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [31:0]      mem_q;
  logic             vld_q;

  // valid bits: reset and case start clear all at once
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : 32'd0;

endmodule

`default_nettype wire

/* rtl/efsd_min2.sv */
`timescale 1ns / 1ps
`default_nettype none

// Running two-smallest tracker, fed one entry per cycle while en is high, in index order.
// Strict compares keep the lower index on ties.
module efsd_min2 #(
  parameter int IW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic          en,
  input  wire logic [31:0]   val,
  input  wire logic [IW-1:0] idx,
  output logic               has1,
  output logic               has2,
  output logic [31:0]        b1,
  output logic [IW-1:0]      i1,
  output logic [31:0]        b2,
  output logic [IW-1:0]      i2
);

  // flags
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      has1 <= 1'b0;
      has2 <= 1'b0;
    end else if (en) begin
      has1 <= 1'b1;
      if (has1) begin
        has2 <= 1'b1;
      end
    end
  end

  // best and runner-up
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (!has1) begin
        b1 <= val;
        i1 <= idx;
      end else if (val < b1) begin
        b2 <= b1;
        i2 <= i1;
        b1 <= val;
        i1 <= idx;
      end else if (!has2 || val < b2) begin
        b2 <= val;
        i2 <= idx;
      end else begin
        // not among the two smallest, both kept
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/earliest_free_server_dispatch.sv */
//  channel   direction  handshake           payload
//  in        input      in_valid/in_stall   in_data   (efsd_pkg::in_req_t)
//  out       output     out_valid/out_stall out_data  (efsd_pkg::out_res_t)
//  cfg       input      cfg_we              cfg_data  (num_servers, 5 bits)
//
//  After acceptance the N servers in use (N = servers in use) are read through
//  the single read port; the block waits for the last read to return, leaves
//  the scan, then loads the result in the update state. A new request is accepted only after the result is loaded.
//  Reset (rst, synchronous) zeroes all finish times and sets num_servers 16.
//  in_stall is high from acceptance until the result is loaded.
//  A stalled result holds the update cycle until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module earliest_free_server_dispatch #(
  parameter int MAX_SERVERS = efsd_pkg::MAX_SERVERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire efsd_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output efsd_pkg::out_res_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data
);

  import efsd_pkg::*;

  localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);

  state_t          state, state_next;
  logic [4:0]      num_servers;
  logic [CW-1:0]   count;
  logic [8:0]      ns_ext;
  logic [CW-1:0]   iss;
  logic            rvalid;
  logic [IW-1:0]   ridx;
  logic [15:0]     svc;
  logic            last;
  logic            accept, issue, load;
  logic [31:0]     rd_data;
  logic            has1, has2;
  logic [31:0]     b1, b2;
  logic [IW-1:0]   i1, i2;
  logic [32:0]     sum;
  logic [31:0]     end_t;
  logic [IW-1:0]   next_idx;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NUM_SERVERS_RST;
    end else if (cfg_we) begin
      num_servers <= cfg_data;
    end
  end

  // servers in use, clamped to 1..MAX_SERVERS
  always_comb begin
    ns_ext = 9'(num_servers);
    priority if (ns_ext == 9'd0) begin
      count = CW'(1);
    end else if (ns_ext > 9'(MAX_SERVERS)) begin
      count = CW'(MAX_SERVERS);
    end else begin
      count = CW'(ns_ext);
    end
  end

  // sequencer outputs
  always_comb begin
    accept   = (state == ST_IDLE) && in_valid;
    issue    = (state == ST_SCAN) && (iss < count);
    load     = (state == ST_UPDATE) && (!out_valid || !out_stall);
    in_stall = (state != ST_IDLE);
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (!issue && !rvalid) state_next = ST_UPDATE;
      ST_UPDATE: if (load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan counter and read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      iss    <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= issue;
      if (accept) begin
        iss <= '0;
      end else if (issue) begin
        iss <= iss + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= iss[IW-1:0];
    if (accept) begin
      svc  <= in_data.service_time;
      last <= in_data.last_of_case;
    end
  end

  efsd_store #(
    .DEPTH (MAX_SERVERS),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clr_all (accept && in_data.first_of_case),
    .wr_en   (load),
    .wr_addr (i1),
    .wr_data (end_t),
    .rd_en   (issue),
    .rd_addr (iss[IW-1:0]),
    .rd_data (rd_data)
  );

  efsd_min2 #(
    .IW (IW)
  ) u_min2 (
    .clk  (clk),
    .rst  (rst),
    .clr  (accept),
    .en   (rvalid),
    .val  (rd_data),
    .idx  (ridx),
    .has1 (has1),
    .has2 (has2),
    .b1   (b1),
    .i1   (i1),
    .b2   (b2),
    .i2   (i2)
  );

  // saturating finish time and next server after the update
  always_comb begin
    sum   = {1'b0, b1} + 33'(svc);
    end_t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    priority if (!has2) begin
      next_idx = i1;
    end else if (end_t < b2) begin
      next_idx = i1;
    end else if (end_t == b2) begin
      next_idx = (i1 < i2) ? i1 : i2;
    end else begin
      next_idx = i2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.assigned_server  <= 4'(i1);
      out_data.start_time       <= b1;
      out_data.end_time         <= end_t;
      out_data.next_free_server <= 4'(next_idx);
      out_data.answer_valid     <= last;
    end
  end

  // an accepted request always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN))
    else $error("accepted request did not start a scan");

  // every read returned belongs to a server in use
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (CW'(ridx) < count))
    else $error("read beyond servers in use");

  // update sees a full scan
  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (has1 && (has2 || count == CW'(1))))
    else $error("update without a complete scan");

  // a finish time never moves backward
  a_end_ge_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.end_time >= out_data.start_time))
    else $error("end time below start time");

endmodule

`default_nettype wire
